// ----- hw/rtl/longest_ones_run_with_flips_macros.svh -----
// assertion macros for the longest ones run block
// expects clock and reset in the scope of the module that uses them
`ifndef LONGEST_ONES_RUN_WITH_FLIPS_MACROS_SVH
`define LONGEST_ONES_RUN_WITH_FLIPS_MACROS_SVH
`ifndef SYNTH
`define LORF_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define LORF_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LORF_ASSERT(label, ante, cons, msg)
`define LORF_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/lorf_pkg.sv -----
// shared types and constants of the longest ones run block
// no dependencies
package lorf_pkg;

   localparam int SEQ_LEN_MAX_DEF = 4096;
   localparam int MAX_FLIPS_DEF   = 255;

   localparam int CFG_W    = 8;
   localparam int IDX_OUT_W = 12;
   localparam int LEN_OUT_W = 13;

   typedef struct packed {
      logic bit_value;
      logic is_last;
   } lorf_req_type;

   typedef struct packed {
      logic                 found;
      logic [IDX_OUT_W-1:0] run_start;
      logic [IDX_OUT_W-1:0] run_end;
      logic [LEN_OUT_W-1:0] run_length;
   } lorf_rsp_type;

   // window update performed in the tracking stage
   typedef enum logic [1:0] {
      OP_KEEP,
      OP_SKIP,
      OP_JUMP,
      OP_POP
   } lorf_op_type;

   typedef struct packed {
      logic        valid;
      logic        last;
      lorf_op_type op;
   } lorf_item_type;

endpackage

// ----- hw/rtl/lorf_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// read-first on a same-address collision; no dependencies
module lorf_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 255
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/lorf_front.sv -----
// accept stage: config register, position counter, zero fifo pointers
// uses lorf_pkg and the assertion macro header
`include "longest_ones_run_with_flips_macros.svh"
module lorf_front #(
   parameter int SEQ_LEN_MAX = lorf_pkg::SEQ_LEN_MAX_DEF,
   parameter int MAX_FLIPS   = lorf_pkg::MAX_FLIPS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_valid,
   input  logic [lorf_pkg::CFG_W-1:0]                  csr_data,
   input  logic                                        accept,
   input  lorf_pkg::lorf_req_type                      req,
   input  logic                                        hold,
   output logic                                        ram_wr_en,
   output logic [(MAX_FLIPS > 1 ? $clog2(MAX_FLIPS) : 1)-1:0] ram_wr_addr,
   output logic [$clog2(SEQ_LEN_MAX)-1:0]              ram_wr_data,
   output logic                                        ram_rd_en,
   output logic [(MAX_FLIPS > 1 ? $clog2(MAX_FLIPS) : 1)-1:0] ram_rd_addr,
   output lorf_pkg::lorf_item_type                     item,
   output logic [$clog2(SEQ_LEN_MAX)-1:0]              item_pos
);

   localparam int PTR_W = MAX_FLIPS > 1 ? $clog2(MAX_FLIPS) : 1;
   localparam int CNT_W = $clog2(MAX_FLIPS + 1);
   localparam int POS_W = $clog2(SEQ_LEN_MAX + 1);
   localparam int IDX_W = $clog2(SEQ_LEN_MAX);

   logic [lorf_pkg::CFG_W-1:0] max_flips_ff;
   logic [POS_W-1:0]           position_ff, position_in;
   logic [PTR_W-1:0]           head_ff, head_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   lorf_pkg::lorf_item_type    item_ff, item_in;
   logic [IDX_W-1:0]           item_pos_ff;

   logic [CNT_W-1:0] limit;
   logic [CNT_W:0]   tail_sum;
   logic [PTR_W-1:0] tail;
   logic [PTR_W-1:0] head_inc;
   logic             in_range;
   lorf_pkg::lorf_op_type op;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      if (32'(max_flips_ff) > 32'(MAX_FLIPS)) begin
         limit = CNT_W'(MAX_FLIPS);
      end else begin
         limit = CNT_W'(max_flips_ff);
      end
      tail_sum = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(count_ff);
      if (tail_sum >= (CNT_W + 1)'(MAX_FLIPS)) begin
         tail = PTR_W'(tail_sum - (CNT_W + 1)'(MAX_FLIPS));
      end else begin
         tail = PTR_W'(tail_sum);
      end
      if (head_ff == PTR_W'(MAX_FLIPS - 1)) begin
         head_inc = '0;
      end else begin
         head_inc = head_ff + 1'b1;
      end
      in_range = position_ff < POS_W'(SEQ_LEN_MAX);

      do_push = 1'b0;
      do_pop  = 1'b0;
      priority if (!in_range) begin
         op = lorf_pkg::OP_SKIP;
      end else if (req.bit_value) begin
         op = lorf_pkg::OP_KEEP;
      end else if (limit == '0) begin
         op = lorf_pkg::OP_JUMP;
      end else if (count_ff >= limit) begin
         op      = lorf_pkg::OP_POP;
         do_push = 1'b1;
         do_pop  = 1'b1;
      end else begin
         op      = lorf_pkg::OP_KEEP;
         do_push = 1'b1;
      end

      position_in = position_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      if (accept) begin
         if (in_range) begin
            position_in = position_ff + 1'b1;
         end
         if (do_pop) begin
            head_in = head_inc;
         end else if (do_push) begin
            count_in = count_ff + 1'b1;
         end
         if (req.is_last) begin
            position_in = '0;
            head_in     = '0;
            count_in    = '0;
         end
      end

      item_in = item_ff;
      if (accept) begin
         item_in.valid = 1'b1;
         item_in.last  = req.is_last;
         item_in.op    = op;
      end else if (!hold) begin
         item_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_flips_ff <= '0;
         position_ff  <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         item_ff      <= '{valid: 1'b0, last: 1'b0, op: lorf_pkg::OP_KEEP};
      end else begin
         if (csr_valid) begin
            max_flips_ff <= csr_data;
         end
         position_ff <= position_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
         item_ff     <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_pos_ff <= position_ff[IDX_W-1:0];
      end
   end

   assign ram_wr_en   = accept && do_push;
   assign ram_wr_addr = tail;
   assign ram_wr_data = position_ff[IDX_W-1:0];
   assign ram_rd_en   = accept && do_pop;
   assign ram_rd_addr = head_ff;
   assign item        = item_ff;
   assign item_pos    = item_pos_ff;

   `LORF_ASSERT(a_count_bound, 1'b1, count_ff <= CNT_W'(MAX_FLIPS), "fifo count overflow")
   `LORF_ASSERT(a_head_bound, 1'b1, head_ff <= PTR_W'(MAX_FLIPS - 1), "fifo head out of range")
   `LORF_ASSERT_NXT(a_last_clears, accept && req.is_last,
      count_ff == '0 && head_ff == '0 && position_ff == '0, "sequence state not cleared")

endmodule

// ----- hw/rtl/lorf_track.sv -----
// update stage: window start, best window and result register
// uses lorf_pkg and the assertion macro header
`include "longest_ones_run_with_flips_macros.svh"
module lorf_track #(
   parameter int SEQ_LEN_MAX = lorf_pkg::SEQ_LEN_MAX_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lorf_pkg::lorf_item_type        item,
   input  logic [$clog2(SEQ_LEN_MAX)-1:0] item_pos,
   input  logic [$clog2(SEQ_LEN_MAX)-1:0] oldest_zero,
   output logic                           hold,
   output logic                           rsp_valid,
   output lorf_pkg::lorf_rsp_type         rsp,
   input  logic                           rsp_stall
);

   localparam int POS_W = $clog2(SEQ_LEN_MAX + 1);
   localparam int IDX_W = $clog2(SEQ_LEN_MAX);

   logic [POS_W-1:0]       win_start_ff, win_start_in;
   logic [POS_W-1:0]       best_len_ff, best_len_in;
   logic [IDX_W-1:0]       best_start_ff, best_start_in;
   logic [IDX_W-1:0]       best_end_ff, best_end_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   lorf_pkg::lorf_rsp_type rsp_ff, rsp_in;

   logic [POS_W-1:0] ws_new;
   logic [POS_W-1:0] pos_ext;
   logic [POS_W-1:0] len;
   logic [POS_W-1:0] blen;
   logic [IDX_W-1:0] bstart;
   logic [IDX_W-1:0] bend;
   logic             commit;

   always_comb begin
      pos_ext = POS_W'(item_pos);
      unique case (item.op)
         lorf_pkg::OP_KEEP: ws_new = win_start_ff;
         lorf_pkg::OP_SKIP: ws_new = win_start_ff;
         lorf_pkg::OP_JUMP: ws_new = pos_ext + 1'b1;
         lorf_pkg::OP_POP:  ws_new = POS_W'(oldest_zero) + 1'b1;
         default:           ws_new = win_start_ff;
      endcase
      if (ws_new <= pos_ext) begin
         len = pos_ext - ws_new + 1'b1;
      end else begin
         len = '0;
      end

      blen   = best_len_ff;
      bstart = best_start_ff;
      bend   = best_end_ff;
      if (item.op != lorf_pkg::OP_SKIP && len > best_len_ff) begin
         blen   = len;
         bstart = ws_new[IDX_W-1:0];
         bend   = item_pos;
      end

      hold   = item.valid && item.last && rsp_valid_ff && rsp_stall;
      commit = item.valid && !hold;

      win_start_in  = win_start_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      best_end_in   = best_end_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      if (commit) begin
         if (item.last) begin
            win_start_in      = '0;
            best_len_in       = '0;
            best_start_in     = '0;
            best_end_in       = '0;
            rsp_valid_in      = 1'b1;
            rsp_in.found      = blen != '0;
            rsp_in.run_start  = lorf_pkg::IDX_OUT_W'(bstart);
            rsp_in.run_end    = lorf_pkg::IDX_OUT_W'(bend);
            rsp_in.run_length = lorf_pkg::LEN_OUT_W'(blen);
         end else begin
            win_start_in  = ws_new;
            best_len_in   = blen;
            best_start_in = bstart;
            best_end_in   = bend;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff  <= '0;
         best_len_ff   <= '0;
         best_start_ff <= '0;
         best_end_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         win_start_ff  <= win_start_in;
         best_len_ff   <= best_len_in;
         best_start_ff <= best_start_in;
         best_end_ff   <= best_end_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `LORF_ASSERT(a_empty_result, rsp_valid_ff && !rsp_ff.found,
      rsp_ff.run_length == '0 && rsp_ff.run_start == '0, "empty result carries data")
   `LORF_ASSERT_NXT(a_last_emits, commit && item.last, rsp_valid_ff, "result not registered")
   `LORF_ASSERT(a_best_bound, 1'b1, best_len_ff <= POS_W'(SEQ_LEN_MAX), "best length too large")

endmodule

// ----- hw/rtl/longest_ones_run_with_flips.sv -----
// top level of the longest ones run block with flipped zeros
// uses lorf_pkg, lorf_front, lorf_ram and lorf_track
//
//   port group  direction  handshake          payload
//   req_        in         req_valid/stall    bit_value, is_last
//   rsp_        out        rsp_valid/stall    found, run_start, run_end, run_length
//   csr_        in         csr_valid/ready    max_flips write data
//
// one bit per cycle while req_stall is low; the zero fifo ram is written and read
// at the accept edge; a result is valid once its last bit passes item_ff and rsp_ff
// req_stall rises only while a result waits under rsp_stall and another last bit
// reaches the update stage; csr_ready is always high
// synchronous reset clears all control state; the fifo ram has no clearing pass
module longest_ones_run_with_flips #(
   parameter int SEQ_LEN_MAX = lorf_pkg::SEQ_LEN_MAX_DEF,
   parameter int MAX_FLIPS   = lorf_pkg::MAX_FLIPS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  lorf_pkg::lorf_req_type     req,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output lorf_pkg::lorf_rsp_type     rsp,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lorf_pkg::CFG_W-1:0] csr_data
);

   localparam int PTR_W = MAX_FLIPS > 1 ? $clog2(MAX_FLIPS) : 1;
   localparam int IDX_W = $clog2(SEQ_LEN_MAX);

   logic                    hold;
   logic                    accept;
   logic                    ram_wr_en;
   logic [PTR_W-1:0]        ram_wr_addr;
   logic [IDX_W-1:0]        ram_wr_data;
   logic                    ram_rd_en;
   logic [PTR_W-1:0]        ram_rd_addr;
   logic [IDX_W-1:0]        ram_rd_data;
   lorf_pkg::lorf_item_type item;
   logic [IDX_W-1:0]        item_pos;

   assign req_stall = hold;
   assign accept    = req_valid && !hold;
   assign csr_ready = 1'b1;

   lorf_front #(
      .SEQ_LEN_MAX(SEQ_LEN_MAX),
      .MAX_FLIPS  (MAX_FLIPS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .accept     (accept),
      .req        (req),
      .hold       (hold),
      .ram_wr_en  (ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .ram_rd_en  (ram_rd_en),
      .ram_rd_addr(ram_rd_addr),
      .item       (item),
      .item_pos   (item_pos)
   );

   lorf_ram #(
      .WIDTH(IDX_W),
      .DEPTH(MAX_FLIPS)
   ) u_zero_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   lorf_track #(
      .SEQ_LEN_MAX(SEQ_LEN_MAX)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_pos   (item_pos),
      .oldest_zero(ram_rd_data),
      .hold       (hold),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp),
      .rsp_stall  (rsp_stall)
   );

endmodule

// ----- dv/longest_ones_run_with_flips_tb.sv -----
// testbench for longest_ones_run_with_flips: bit streams with a flip limit,
// results checked against a window tracker kept in the bench
// depends on lorf_pkg and the longest_ones_run_with_flips rtl
`timescale 1ns / 1ps

module longest_ones_run_with_flips_tb;

   localparam int SEQ_LEN     = lorf_pkg::SEQ_LEN_MAX_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 6;
   localparam int LONG_RUN    = 200;
   localparam int LATE_ZEROS  = 100;
   localparam int LATE_ONES   = 60;

   typedef enum int {
      RX_FLOW,
      RX_LIGHT,
      RX_HALF,
      RX_HEAVY
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   lorf_pkg::lorf_req_type req = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   lorf_pkg::lorf_rsp_type rsp;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [lorf_pkg::CFG_W-1:0] csr_data = '0;

   longest_ones_run_with_flips u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // window tracker state
   logic [lorf_pkg::CFG_W-1:0] flips_cfg = '0;
   int unsigned seq_pos = 0;
   int unsigned win_start = 0;
   int unsigned best_len = 0;
   int unsigned best_start = 0;
   int unsigned best_end = 0;
   int unsigned zero_fifo[$];
   lorf_pkg::lorf_rsp_type expected_runs[$];

   int unsigned failures = 0;
   int unsigned cycles = 0;
   int unsigned burst_left = 0;
   bit tx_gapless = 1'b0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   int unsigned mode_left = 0;
   rx_mode_type rx_mode = RX_FLOW;
   lorf_pkg::lorf_rsp_type want;

   function automatic void track_bit(input logic b, input logic last);
      int unsigned len;
      lorf_pkg::lorf_rsp_type run;
      if (seq_pos < SEQ_LEN) begin
         if (!b) begin
            if (flips_cfg == 0) begin
               win_start = seq_pos + 1;
            end else begin
               if (zero_fifo.size() >= flips_cfg) begin
                  win_start = zero_fifo.pop_front() + 1;
               end
               zero_fifo = {zero_fifo, seq_pos};
            end
         end
         len = (win_start <= seq_pos) ? seq_pos - win_start + 1 : 0;
         if (len > best_len) begin
            best_len = len;
            best_start = win_start;
            best_end = seq_pos;
         end
         seq_pos++;
      end
      if (last) begin
         run.found = (best_len > 0);
         run.run_start = lorf_pkg::IDX_OUT_W'(best_start);
         run.run_end = lorf_pkg::IDX_OUT_W'(best_end);
         run.run_length = lorf_pkg::LEN_OUT_W'(best_len);
         expected_runs = {expected_runs, run};
         seq_pos = 0;
         win_start = 0;
         best_len = 0;
         best_start = 0;
         best_end = 0;
         zero_fifo.delete();
      end
   endfunction

   task automatic send_bit(input logic b, input logic last);
      lorf_pkg::lorf_req_type item;
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = (tx_gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      item.bit_value = b;
      item.is_last = last;
      req <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_bit(b, last);
      burst_left--;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_runs.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_max_flips(input logic [lorf_pkg::CFG_W-1:0] value);
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      flips_cfg = value;
   endtask

   task automatic send_pattern(input string bits);
      for (int i = 0; i < bits.len(); i++) begin
         send_bit(bits[i] == "1", i == bits.len() - 1);
      end
   endtask

   task automatic send_random_seq(input int unsigned len, input int unsigned zero_pct);
      for (int unsigned i = 0; i < len; i++) begin
         send_bit($urandom_range(0, 99) >= zero_pct, i == len - 1);
      end
   endtask

   task automatic test_zero_limit();
      write_max_flips(8'd0);
      send_pattern("0");
      send_pattern("1");
      send_pattern("11011");
      send_pattern("000");
      send_pattern("010");
      wait_idle();
   endtask

   task automatic test_small_limits();
      write_max_flips(8'd1);
      send_pattern("101101");
      send_pattern("0");
      wait_idle();
      write_max_flips(8'd255);
      send_pattern("0100");
      wait_idle();
   endtask

   task automatic test_long_ones();
      write_max_flips(8'd0);
      for (int i = 0; i < LONG_RUN; i++) send_bit(1'b1, i == LONG_RUN - 1);
      wait_idle();
   endtask

   task automatic test_late_window();
      for (int i = 0; i < LATE_ZEROS; i++) send_bit(1'b0, 1'b0);
      for (int i = 0; i < LATE_ONES; i++) send_bit(1'b1, i == LATE_ONES - 1);
      wait_idle();
   endtask

   task automatic test_fifo_wrap();
      write_max_flips(8'd255);
      send_random_seq(560, 96);
      wait_idle();
   endtask

   task automatic test_input_backpressure();
      write_max_flips(8'd2);
      tx_gapless = 1'b1;
      hold_requests++;
      for (int i = 0; i < 120; i++) begin
         send_bit(1'($urandom_range(0, 1)), $urandom_range(0, 2) != 0);
      end
      send_bit(1'b1, 1'b1);
      tx_gapless = 1'b0;
      wait_idle();
   endtask

   task automatic test_random_runs();
      logic [lorf_pkg::CFG_W-1:0] settings[7];
      int unsigned sent;
      int unsigned len;
      int unsigned pct;
      settings = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd3, 8'd0, 8'd0};
      settings[5] = 8'($urandom_range(4, 16));
      settings[6] = 8'($urandom_range(0, 255));
      foreach (settings[s]) begin
         write_max_flips(settings[s]);
         sent = 0;
         while (sent < 40) begin
            tx_gapless = ($urandom_range(0, 4) == 0);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 150) :
                                                $urandom_range(1, 40);
            case ($urandom_range(0, 5))
               0: pct = 0;
               1: pct = 100;
               2: pct = 10;
               3: pct = 30;
               4: pct = 50;
               default: pct = 80;
            endcase
            send_random_seq(len, pct);
            sent += len;
         end
         tx_gapless = 1'b0;
         wait_idle();
      end
   endtask

   // receiver stall pattern, with long holds on request
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (rx_mode)
            RX_FLOW: rsp_stall <= 1'b0;
            RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            RX_HALF: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_runs.size() == 0) begin
            $display("%0t: unexpected transaction, actual %p", $time, rsp);
            failures++;
         end else begin
            want = expected_runs.pop_front();
            if (rsp.found !== want.found) begin
               $display("%0t: found expected %0d actual %0d", $time, want.found, rsp.found);
               failures++;
            end
            if (rsp.run_start !== want.run_start) begin
               $display("%0t: run_start expected %0d actual %0d",
                        $time, want.run_start, rsp.run_start);
               failures++;
            end
            if (rsp.run_end !== want.run_end) begin
               $display("%0t: run_end expected %0d actual %0d",
                        $time, want.run_end, rsp.run_end);
               failures++;
            end
            if (rsp.run_length !== want.run_length) begin
               $display("%0t: run_length expected %0d actual %0d",
                        $time, want.run_length, rsp.run_length);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zero_limit();
      test_small_limits();
      test_long_ones();
      test_late_window();
      test_fifo_wrap();
      test_input_backpressure();
      test_random_runs();
      wait_idle();
      if (failures == 0 && expected_runs.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
